/* hw/rtl/brfr_pkg.sv */
// ----------------------------------------------------------------------------
// brfr_pkg: shared types and codes for the byte ring FIFO with rewind
// Holds the mode and status codes, the decoded operation type, the command
// beat that travels from the front end to the execute unit, and queue status.
// ----------------------------------------------------------------------------
package brfr_pkg;

   // Field widths of the request and response beats.
   localparam int MODE_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 12;
   localparam int LEN_W    = 13;
   localparam int CAP_W    = 13;
   localparam int STAT_W   = 2;
   localparam int FILL_W   = 13;

   // Request mode codes.
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REW_WR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REW_RD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVER   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDER  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BADREW = 2'd3;

   // Depth of the command queue between front end and execute unit.
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_READ   = 3'd1,
      OP_REW_WR = 3'd2,
      OP_REW_RD = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_NOP    = 3'd5
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  wbyte;
      logic [POS_W-1:0]   pos;
      logic [LEN_W-1:0]   len;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* hw/rtl/brfr_front.sv */
// ----------------------------------------------------------------------------
// brfr_front: request intake and mode decode
// Takes a request beat, decodes its mode into an operation and holds it in a
// one-entry stage until the command queue has room.
// ----------------------------------------------------------------------------
module brfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brfr_pkg::MODE_W-1:0]   req_mode,
   input  logic [brfr_pkg::BYTE_W-1:0]   req_write_byte,
   input  logic [brfr_pkg::POS_W-1:0]    req_position,
   input  logic [brfr_pkg::LEN_W-1:0]    req_length,
   input  brfr_pkg::q_stat_type          q_stat,
   output logic                          push,
   output brfr_pkg::cmd_type             push_cmd
);

   logic              vld_ff, vld_in;
   brfr_pkg::cmd_type cmd_ff, cmd_in;
   brfr_pkg::cmd_type dec_cmd;
   logic              accept;

   always_comb begin
      dec_cmd.wbyte = req_write_byte;
      dec_cmd.pos   = req_position;
      dec_cmd.len   = req_length;
      unique case (req_mode)
         brfr_pkg::MODE_WRITE:  dec_cmd.op = brfr_pkg::OP_WRITE;
         brfr_pkg::MODE_READ:   dec_cmd.op = brfr_pkg::OP_READ;
         brfr_pkg::MODE_REW_WR: dec_cmd.op = brfr_pkg::OP_REW_WR;
         brfr_pkg::MODE_REW_RD: dec_cmd.op = brfr_pkg::OP_REW_RD;
         brfr_pkg::MODE_CLEAR:  dec_cmd.op = brfr_pkg::OP_CLEAR;
         default:               dec_cmd.op = brfr_pkg::OP_NOP;
      endcase
   end

   // The held beat moves on whenever the queue has room; a new beat may
   // enter in the same cycle.
   assign push     = vld_ff & ~q_stat.full;
   assign push_cmd = cmd_ff;
   assign busy     = vld_ff & q_stat.full;
   assign accept   = start & ~busy;

   always_comb begin
      vld_in = accept | (vld_ff & ~push);
      cmd_in = accept ? dec_cmd : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

/* hw/rtl/brfr_cmdq.sv */
// ----------------------------------------------------------------------------
// brfr_cmdq: command queue
// Small FIFO of decoded commands between the front end and the execute unit.
// ----------------------------------------------------------------------------
module brfr_cmdq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  brfr_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output brfr_pkg::cmd_type    pop_cmd,
   output brfr_pkg::q_stat_type q_stat
);

   localparam int QA_W = (brfr_pkg::CMDQ_DEPTH > 1) ? $clog2(brfr_pkg::CMDQ_DEPTH) : 1;
   localparam int QC_W = $clog2(brfr_pkg::CMDQ_DEPTH + 1);
   localparam logic [QA_W-1:0] LAST = QA_W'(brfr_pkg::CMDQ_DEPTH - 1);
   localparam logic [QC_W-1:0] FULL = QC_W'(brfr_pkg::CMDQ_DEPTH);

   brfr_pkg::cmd_type entry_ff [brfr_pkg::CMDQ_DEPTH];
   logic [QA_W-1:0]   wr_ff, wr_in;
   logic [QA_W-1:0]   rd_ff, rd_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_stat.full  = (cnt_ff == FULL);
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_cmd      = entry_ff[rd_ff];

   assign do_push = push & ~q_stat.full;
   assign do_pop  = pop & ~q_stat.empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/brfr_exec.sv */
// ----------------------------------------------------------------------------
// brfr_exec: execute unit
// Owns the byte store, both ring pointers, the fill count and the capacity
// register. Runs one command in an execute cycle and shows its response in
// the following cycle.
// ----------------------------------------------------------------------------
module brfr_exec #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [brfr_pkg::CAP_W-1:0]    csr_wdata,
   input  brfr_pkg::q_stat_type          q_stat,
   input  brfr_pkg::cmd_type             q_cmd,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [brfr_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic [brfr_pkg::STAT_W-1:0]   rsp_status,
   output logic [brfr_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic [brfr_pkg::POS_W-1:0]    rsp_write_pos,
   output logic [brfr_pkg::POS_W-1:0]    rsp_read_pos,
   output logic                          rsp_would_overflow
);

   localparam int PW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int WW = (CW > brfr_pkg::LEN_W) ? CW : brfr_pkg::LEN_W;
   localparam int SW = WW + 1;
   localparam int CAP_RST = (STORE_DEPTH < 4096) ? STORE_DEPTH : 4096;
   localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
   localparam logic [SW-1:0] ONE_S   = SW'(1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   brfr_pkg::cmd_type             cmd_ff, cmd_in;
   logic [PW-1:0]                 wp_ff, wp_in;
   logic [PW-1:0]                 rp_ff, rp_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 cap_ff, cap_in;
   logic [brfr_pkg::STAT_W-1:0]   status_ff, status_in;
   logic                          rd_ok_ff, rd_ok_in;
   logic [brfr_pkg::BYTE_W-1:0]   rdata_ff;
   logic [brfr_pkg::BYTE_W-1:0]   store_mem [STORE_DEPTH];
   logic                          mem_we, mem_re;

   logic [SW-1:0] cap_s, cnt_s, wp_s, rp_s, pos_s, len_s, ptr_s;
   logic [SW-1:0] dist_s, wp_inc_s, rp_inc_s, wdata_s, sat_s;
   logic [SW-1:0] wp_out_s, rp_out_s;

   assign cap_s   = SW'(cap_ff);
   assign cnt_s   = SW'(cnt_ff);
   assign wp_s    = SW'(wp_ff);
   assign rp_s    = SW'(rp_ff);
   assign pos_s   = SW'(cmd_ff.pos);
   assign len_s   = SW'(cmd_ff.len);
   assign wp_inc_s = wp_s + ONE_S;
   assign rp_inc_s = rp_s + ONE_S;

   // Backward distance from the pointer being rewound to the target position.
   assign ptr_s  = (cmd_ff.op == brfr_pkg::OP_REW_WR) ? wp_s : rp_s;
   assign dist_s = (pos_s <= ptr_s) ? (ptr_s - pos_s) : (ptr_s + cap_s - pos_s);

   // Capacity written through the register port, saturated to 1..STORE_DEPTH.
   assign wdata_s = SW'(csr_wdata);
   assign sat_s   = (wdata_s == '0) ? ONE_S : ((wdata_s > DEPTH_S) ? DEPTH_S : wdata_s);

   assign mem_re = (state_ff == S_EXEC) && (cmd_ff.op == brfr_pkg::OP_READ);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      cnt_in    = cnt_ff;
      cap_in    = cap_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      mem_we    = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_RESP;
            status_in = brfr_pkg::STAT_OK;
            rd_ok_in  = 1'b0;
            unique case (cmd_ff.op)
               brfr_pkg::OP_WRITE: begin
                  if (cnt_s >= cap_s) begin
                     status_in = brfr_pkg::STAT_OVER;
                  end else begin
                     mem_we = 1'b1;
                     wp_in  = (wp_inc_s >= cap_s) ? '0 : wp_inc_s[PW-1:0];
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               brfr_pkg::OP_READ: begin
                  if (cnt_ff == '0) begin
                     status_in = brfr_pkg::STAT_UNDER;
                  end else begin
                     rd_ok_in = 1'b1;
                     rp_in    = (rp_inc_s >= cap_s) ? '0 : rp_inc_s[PW-1:0];
                     cnt_in   = cnt_ff - 1'b1;
                  end
               end
               brfr_pkg::OP_REW_WR: begin
                  if ((pos_s >= cap_s) || (dist_s > cnt_s)) begin
                     status_in = brfr_pkg::STAT_BADREW;
                  end else begin
                     wp_in  = pos_s[PW-1:0];
                     cnt_in = cnt_ff - dist_s[CW-1:0];
                  end
               end
               brfr_pkg::OP_REW_RD: begin
                  if ((pos_s >= cap_s) || ((cnt_s + dist_s) > cap_s)) begin
                     status_in = brfr_pkg::STAT_BADREW;
                  end else begin
                     rp_in  = pos_s[PW-1:0];
                     cnt_in = cnt_ff + dist_s[CW-1:0];
                  end
               end
               brfr_pkg::OP_CLEAR: begin
                  wp_in  = '0;
                  rp_in  = '0;
                  cnt_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_RESP: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_we) begin
         cap_in = sat_s[CW-1:0];
         wp_in  = '0;
         rp_in  = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         cnt_ff   <= '0;
         cap_ff   <= CW'(CAP_RST);
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         cnt_ff   <= cnt_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wp_ff] <= cmd_ff.wbyte;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[rp_ff];
      end
   end

   assign wp_out_s = wp_s;
   assign rp_out_s = rp_s;

   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_read_byte      = rd_ok_ff ? rdata_ff : '0;
   assign rsp_status         = status_ff;
   assign rsp_fill_count     = cnt_s[brfr_pkg::FILL_W-1:0];
   assign rsp_write_pos      = wp_out_s[brfr_pkg::POS_W-1:0];
   assign rsp_read_pos       = rp_out_s[brfr_pkg::POS_W-1:0];
   assign rsp_would_overflow = ((cnt_s + len_s) > cap_s);

endmodule

/* hw/rtl/byte_ring_fifo_with_rewind.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind: circular byte FIFO with pointer rewind
// A byte store used as a ring of configurable capacity, driven by byte write,
// byte read, write-pointer rewind, read-pointer rewind and clear commands.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Beat contents
//   --------  ---------------------  ------------------------------------------
//   request   start high, busy low   mode, write byte, position, length
//   response  rsp_valid for 1 cycle  read byte, status, fill count, pointers,
//                                    overflow flag
//   config    csr_we                 capacity
//
// A request beat is registered by the front end, then moves through a
// two-entry command queue to the execute unit. The execute unit runs the
// command in its execute state (store write or store read, pointer and count
// update) and presents the response in the respond state after it, so it
// finishes one command before it takes another from the queue. The execute
// and respond states lie around the registered read of the byte store.
// Reset is synchronous and clears the pointers, the fill count, the queue and
// sets the capacity to 4096 (limited to STORE_DEPTH); the store contents are
// not cleared. The response receiver cannot stall, so busy rises only when
// the queue and the front-end stage are both full.
//
// Writing the capacity clears both pointers and the fill count. A capacity of
// zero acts as one and a capacity above STORE_DEPTH acts as STORE_DEPTH.
// Rejected operations (write when full, read when empty, bad rewind) leave the
// state untouched and report their status code.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_rewind #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brfr_pkg::MODE_W-1:0]   req_mode,
   input  logic [brfr_pkg::BYTE_W-1:0]   req_write_byte,
   input  logic [brfr_pkg::POS_W-1:0]    req_position,
   input  logic [brfr_pkg::LEN_W-1:0]    req_length,
   output logic                          rsp_valid,
   output logic [brfr_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic [brfr_pkg::STAT_W-1:0]   rsp_status,
   output logic [brfr_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic [brfr_pkg::POS_W-1:0]    rsp_write_pos,
   output logic [brfr_pkg::POS_W-1:0]    rsp_read_pos,
   output logic                          rsp_would_overflow,
   input  logic                          csr_we,
   input  logic [brfr_pkg::CAP_W-1:0]    csr_wdata
);

   // Command handoff between the front end, the queue and the execute unit.
   brfr_pkg::q_stat_type q_stat;
   brfr_pkg::cmd_type    push_cmd;
   brfr_pkg::cmd_type    pop_cmd;
   logic                 push;
   logic                 pop;

   // Front end: takes request beats and decodes the mode.
   brfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_write_byte (req_write_byte),
      .req_position   (req_position),
      .req_length     (req_length),
      .q_stat         (q_stat),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // Decouples intake from execution so each side stalls on its own.
   brfr_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   // Back end: byte store, ring pointers, fill count and capacity register.
   brfr_exec #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_exec (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .q_stat             (q_stat),
      .q_cmd              (pop_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_status         (rsp_status),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_write_pos      (rsp_write_pos),
      .rsp_read_pos       (rsp_read_pos),
      .rsp_would_overflow (rsp_would_overflow)
   );

endmodule

/* verif/brfr_checker.sv */
// ----------------------------------------------------------------------------
// brfr_checker: response checker for the byte ring FIFO with rewind
// Watches the request, response and capacity ports, keeps its own copy of
// the ring state, predicts one response beat per accepted request and
// compares every response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module brfr_checker #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [brfr_pkg::MODE_W-1:0]   req_mode,
   input  logic [brfr_pkg::BYTE_W-1:0]   req_write_byte,
   input  logic [brfr_pkg::POS_W-1:0]    req_position,
   input  logic [brfr_pkg::LEN_W-1:0]    req_length,
   input  logic                          rsp_valid,
   input  logic [brfr_pkg::BYTE_W-1:0]   rsp_read_byte,
   input  logic [brfr_pkg::STAT_W-1:0]   rsp_status,
   input  logic [brfr_pkg::FILL_W-1:0]   rsp_fill_count,
   input  logic [brfr_pkg::POS_W-1:0]    rsp_write_pos,
   input  logic [brfr_pkg::POS_W-1:0]    rsp_read_pos,
   input  logic                          rsp_would_overflow,
   input  logic                          csr_we,
   input  logic [brfr_pkg::CAP_W-1:0]    csr_wdata,
   output int                            mismatch_count,
   output int                            beats_pending
);
   import brfr_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic [STAT_W-1:0] status;
      logic [FILL_W-1:0] fill_count;
      logic [POS_W-1:0]  write_pos;
      logic [POS_W-1:0]  read_pos;
      logic              would_overflow;
   } fifo_beat_type;

   logic [BYTE_W-1:0] ring_store [STORE_DEPTH];
   int                wr_ptr;
   int                rd_ptr;
   int                held;
   int                cap_setting;
   int                mismatches = 0;
   fifo_beat_type     expected_beats [$];

   // Applies one operation to the shadow ring and returns the response beat.
   function automatic fifo_beat_type predict_fifo_beat(input logic [MODE_W-1:0] mode,
                                                       input logic [BYTE_W-1:0] wbyte,
                                                       input logic [POS_W-1:0]  pos,
                                                       input logic [LEN_W-1:0]  len);
      fifo_beat_type beat;
      int            cap;
      int            target;
      int            back_dist;
      beat   = '0;
      target = pos;
      cap    = (cap_setting < 1) ? 1 :
               (cap_setting > STORE_DEPTH) ? STORE_DEPTH : cap_setting;
      if (wr_ptr >= cap) wr_ptr = 0;
      if (rd_ptr >= cap) rd_ptr = 0;
      if (held > cap) held = cap;
      case (mode)
         MODE_WRITE: begin
            if (held + 1 > cap) begin
               beat.status = STAT_OVER;
            end else begin
               ring_store[wr_ptr] = wbyte;
               wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
               held++;
            end
         end
         MODE_READ: begin
            if (held == 0) begin
               beat.status = STAT_UNDER;
            end else begin
               beat.read_byte = ring_store[rd_ptr];
               rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
               held--;
            end
         end
         MODE_REW_WR: begin
            back_dist = (target <= wr_ptr) ? wr_ptr - target : wr_ptr + cap - target;
            if (target >= cap || back_dist > held) begin
               beat.status = STAT_BADREW;
            end else begin
               wr_ptr = target;
               held -= back_dist;
            end
         end
         MODE_REW_RD: begin
            back_dist = (target <= rd_ptr) ? rd_ptr - target : rd_ptr + cap - target;
            if (target >= cap || held + back_dist > cap) begin
               beat.status = STAT_BADREW;
            end else begin
               rd_ptr = target;
               held += back_dist;
            end
         end
         MODE_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            held   = 0;
         end
         default: begin
         end
      endcase
      beat.fill_count     = FILL_W'(held);
      beat.write_pos      = POS_W'(wr_ptr);
      beat.read_pos       = POS_W'(rd_ptr);
      beat.would_overflow = (held + int'(len) > cap);
      return beat;
   endfunction

   task automatic check_field(input string field_name, input logic [15:0] expected_value,
                              input logic [15:0] actual_value);
      if (actual_value !== expected_value) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, field_name,
                  expected_value, actual_value);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      fifo_beat_type exp_beat;
      if (reset) begin
         wr_ptr      = 0;
         rd_ptr      = 0;
         held        = 0;
         cap_setting = 4096;
         expected_beats.delete();
      end else begin
         // A response never belongs to a request accepted at the same edge.
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $display("%0t response beat with no request outstanding", $time);
               mismatches++;
            end else begin
               exp_beat = expected_beats.pop_front();
               check_field("read_byte", 16'(exp_beat.read_byte), 16'(rsp_read_byte));
               check_field("status", 16'(exp_beat.status), 16'(rsp_status));
               check_field("fill_count", 16'(exp_beat.fill_count), 16'(rsp_fill_count));
               check_field("write_pos", 16'(exp_beat.write_pos), 16'(rsp_write_pos));
               check_field("read_pos", 16'(exp_beat.read_pos), 16'(rsp_read_pos));
               check_field("would_overflow", 16'(exp_beat.would_overflow),
                           16'(rsp_would_overflow));
            end
         end
         if (csr_we) begin
            cap_setting = csr_wdata;
            wr_ptr      = 0;
            rd_ptr      = 0;
            held        = 0;
         end
         if (start && !busy) begin
            expected_beats.push_back(predict_fifo_beat(req_mode, req_write_byte,
                                                       req_position, req_length));
         end
      end
      beats_pending  <= expected_beats.size();
      mismatch_count <= mismatches;
   end

endmodule

/* verif/tb_byte_ring_fifo_with_rewind.sv */
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_rewind: testbench for the byte ring FIFO with rewind
// Preloads the low part of the store, runs a short directed list of corner
// operations, then random phases over several capacity settings with bursty
// request traffic. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_rewind;
   import brfr_pkg::*;

   localparam int DEPTH          = 4096;
   // Bytes written at the bottom of the store before anything else runs.
   localparam int PRELOAD        = 256;
   localparam int PHASE_BEATS    = 175;
   // No correct run goes this many cycles without a request or response beat.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MODE_MAX       = (1 << MODE_W) - 1;
   localparam int LEN_MAX        = (1 << LEN_W) - 1;
   localparam int POS_MAX        = (1 << POS_W) - 1;
   localparam int CAP_MAX        = (1 << CAP_W) - 1;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                start              = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode           = '0;
   logic [BYTE_W-1:0]   req_write_byte     = '0;
   logic [POS_W-1:0]    req_position       = '0;
   logic [LEN_W-1:0]    req_length         = '0;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [STAT_W-1:0]   rsp_status;
   logic [FILL_W-1:0]   rsp_fill_count;
   logic [POS_W-1:0]    rsp_write_pos;
   logic [POS_W-1:0]    rsp_read_pos;
   logic                rsp_would_overflow;
   logic                csr_we             = 1'b0;
   logic [CAP_W-1:0]    csr_wdata          = '0;
   int                  mismatch_count;
   int                  beats_pending;
   int                  idle_cycles        = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   byte_ring_fifo_with_rewind #(
      .STORE_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_write_byte(req_write_byte),
      .req_position(req_position),
      .req_length(req_length),
      .rsp_valid(rsp_valid),
      .rsp_read_byte(rsp_read_byte),
      .rsp_status(rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_write_pos(rsp_write_pos),
      .rsp_read_pos(rsp_read_pos),
      .rsp_would_overflow(rsp_would_overflow),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   brfr_checker #(
      .STORE_DEPTH(DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_write_byte(req_write_byte),
      .req_position(req_position),
      .req_length(req_length),
      .rsp_valid(rsp_valid),
      .rsp_read_byte(rsp_read_byte),
      .rsp_status(rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_write_pos(rsp_write_pos),
      .rsp_read_pos(rsp_read_pos),
      .rsp_would_overflow(rsp_would_overflow),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .beats_pending(beats_pending)
   );

   // The watchdog restarts whenever a request or a response beat moves. A hung
   // block, or a response that never shows up, lets it run out.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL byte_ring_fifo_with_rewind");
         $finish;
      end
   end

   // Presents one request beat and returns just after the edge that takes it.
   // Start is only ever raised here, so a following beat keeps it high with
   // no low-high glitch inside one time step.
   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] wbyte,
                            input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
      req_mode       <= mode;
      req_write_byte <= wbyte;
      req_position   <= pos;
      req_length     <= len;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds the sender off until the checker has seen every response. The
   // first edge is waited out so that a beat accepted just now is counted.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
   endtask

   // Capacity writes only happen with the block idle. Every request produces
   // exactly one response, so an empty checker means the block is quiet.
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_for_drain();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One random phase at a given capacity. Traffic comes in bursts, and each
   // burst leans toward writes or toward reads so that the ring swings
   // between empty and full instead of hovering near one level. Rewinds
   // mostly aim inside the ring, sometimes anywhere in the position range.
   // On a ring larger than the preloaded part of the store a read rewind
   // could expose bytes that were never written, so there those picks turn
   // into write rewinds; the directed beats cover read rewinds on a big ring.
   task automatic run_random_phase(input logic [CAP_W-1:0] cap_value, input int beat_total);
      int                eff_cap;
      int                burst_left;
      int                pick;
      bit                fill_bias;
      bit                big_ring;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      eff_cap    = (cap_value < 1) ? 1 : (cap_value > DEPTH) ? DEPTH : cap_value;
      big_ring   = (eff_cap > PRELOAD);
      burst_left = 0;
      fill_bias  = 1'b1;
      set_capacity(cap_value);
      for (int n = 0; n < beat_total; n++) begin
         if (n == beat_total / 2) wait_for_drain();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            fill_bias  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
         end
         burst_left--;

         pick = $urandom_range(0, 99);
         if (pick < 25) mode = fill_bias ? MODE_WRITE : MODE_READ;
         else if (pick < 50) mode = fill_bias ? MODE_READ : MODE_WRITE;
         else if (pick < 75) mode = fill_bias ? MODE_WRITE : MODE_READ;
         else if (pick < 85) mode = MODE_REW_WR;
         else if (pick < 95) mode = big_ring ? MODE_REW_WR : MODE_REW_RD;
         else if (pick < 98) mode = MODE_CLEAR;
         else mode = MODE_W'($urandom_range(MODE_CLEAR + 1, MODE_MAX));

         if ((mode == MODE_REW_WR || mode == MODE_REW_RD) && $urandom_range(0, 4) != 0) begin
            pos = POS_W'($urandom_range(0, eff_cap - 1));
         end else begin
            pos = POS_W'($urandom_range(0, POS_MAX));
         end

         pick = $urandom_range(0, 9);
         if (pick == 0) len = '0;
         else if (pick == 1) len = LEN_W'(LEN_MAX);
         else if (pick == 2) len = LEN_W'(DEPTH);
         else if (pick < 6) len = LEN_W'($urandom_range(0, LEN_MAX));
         else len = LEN_W'($urandom_range(0, eff_cap));

         send_beat(mode, BYTE_W'($urandom_range(0, 255)), pos, len);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Write the bottom of the store at full capacity. Every ring of up to
      // PRELOAD bytes then only ever reads bytes that were written.
      set_capacity(CAP_W'(DEPTH));
      for (int n = 0; n < PRELOAD; n++) begin
         send_beat(MODE_WRITE, BYTE_W'($urandom_range(0, 255)),
                   POS_W'($urandom_range(0, POS_MAX)), LEN_W'($urandom_range(0, LEN_MAX)));
      end

      // Directed corners at capacity 4096. The read pointer sits at zero and
      // the write pointer just past the preloaded bytes.
      send_beat(MODE_REW_RD, 8'h00, 12'd1, '0);                // read rewind beyond capacity
      send_beat(MODE_REW_RD, 8'h00, POS_W'(PRELOAD), '0);      // read rewind filling the ring
      send_beat(MODE_WRITE, 8'hFF, '0, '0);                    // write when full
      send_beat(MODE_WRITE, 8'h00, POS_W'(POS_MAX), LEN_W'(LEN_MAX)); // overflow query set
      send_beat(MODE_REW_WR, 8'h00, POS_W'(POS_MAX), LEN_W'(DEPTH));  // write rewind wrapping
      send_beat(MODE_REW_WR, 8'h00, POS_W'(PRELOAD), '0);      // rewind drops every held byte
      send_beat(MODE_READ, 8'h00, '0, LEN_W'(DEPTH));          // read when empty
      send_beat(MODE_REW_WR, 8'h00, 12'd5, '0);                // write rewind past held bytes
      send_beat(MODE_REW_RD, 8'h00, POS_W'(PRELOAD - 1), '0);  // read rewind by one byte
      send_beat(MODE_READ, 8'h00, '0, '0);                     // read the re-exposed byte
      send_beat(MODE_CLEAR, 8'h00, '0, '0);
      send_beat(MODE_REW_RD, 8'h00, POS_W'(POS_MAX), '0);      // read rewind wrapping back
      send_beat(MODE_REW_WR, 8'h00, POS_W'(POS_MAX), '0);      // write rewind wrapping back
      send_beat(MODE_WRITE, 8'hA5, '0, 13'd1);                 // write pointer wraps to zero
      send_beat(MODE_READ, 8'h00, '0, '0);                     // read pointer wraps to zero
      send_beat(MODE_REW_RD, 8'h00, POS_W'(POS_MAX), '0);
      send_beat(MODE_READ, 8'h00, '0, '0);                     // the same byte once more
      send_beat(MODE_REW_RD, 8'h00, '0, '0);                   // zero-distance read rewind
      send_beat(MODE_CLEAR, 8'hFF, POS_W'(POS_MAX), LEN_W'(LEN_MAX));
      for (int m = MODE_CLEAR + 1; m <= MODE_MAX; m++) begin
         send_beat(MODE_W'(m), 8'hFF, POS_W'(POS_MAX), LEN_W'(LEN_MAX)); // unused modes
      end

      // Directed corners on a three-byte ring.
      set_capacity(13'd3);
      send_beat(MODE_REW_WR, 8'h00, POS_W'(POS_MAX), '0);  // position beyond capacity
      send_beat(MODE_REW_RD, 8'h00, 12'd3, '0);            // position equal to capacity
      send_beat(MODE_WRITE, 8'h11, '0, 13'd3);
      send_beat(MODE_WRITE, 8'h22, '0, 13'd2);
      send_beat(MODE_WRITE, 8'h33, '0, 13'd1);
      send_beat(MODE_WRITE, 8'h44, '0, '0);                // write when full
      send_beat(MODE_REW_RD, 8'h00, 12'd1, '0);            // read rewind beyond capacity
      send_beat(MODE_READ, 8'h00, '0, '0);
      send_beat(MODE_READ, 8'h00, '0, '0);

      // Random phases, the capacity extremes among them: the all-ones value
      // and values above the store size saturate, zero acts as one.
      run_random_phase(CAP_W'(CAP_MAX), PHASE_BEATS);
      run_random_phase(13'd1, PHASE_BEATS);
      run_random_phase(13'd0, PHASE_BEATS);
      run_random_phase(13'd2, PHASE_BEATS);
      run_random_phase(CAP_W'($urandom_range(3, 16)), PHASE_BEATS);
      run_random_phase(CAP_W'($urandom_range(17, PRELOAD)), PHASE_BEATS);
      run_random_phase(CAP_W'(DEPTH), PHASE_BEATS);
      run_random_phase(CAP_W'(DEPTH + 1), PHASE_BEATS);
      run_random_phase(CAP_W'($urandom_range(1, DEPTH)), PHASE_BEATS);

      // Let every response arrive, then wait on so that the pipeline can show any
      // stray beat before deciding.
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS byte_ring_fifo_with_rewind");
      end else begin
         $display("FAIL byte_ring_fifo_with_rewind");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/brfr_pkg.sv
hw/rtl/brfr_front.sv
hw/rtl/brfr_cmdq.sv
hw/rtl/brfr_exec.sv
hw/rtl/byte_ring_fifo_with_rewind.sv
verif/brfr_checker.sv
verif/tb_byte_ring_fifo_with_rewind.sv
